FILE: hdl/rat_norm_pkg.sv
// ----------------------------------------------------------------------------
// rat_norm_pkg
// Shared widths, operation codes and sequencer states for the rational
// arithmetic and reduction block.
// ----------------------------------------------------------------------------
package rat_norm_pkg;

   // result range limit: the reduced fraction must fit a signed field this wide
   localparam int WIDTH = 32;

   localparam int FIELD_W = 32;               // operand field width
   localparam int MAG_W   = 2 * FIELD_W;      // cross-product magnitude width
   localparam int CNT_W   = $clog2(MAG_W);    // division step and twos count
   localparam int KIND_W  = 3;

   localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_ADD = 3'd0;
   localparam kind_type KIND_SUB = 3'd1;
   localparam kind_type KIND_MUL = 3'd2;
   localparam kind_type KIND_DIV = 3'd3;
   localparam kind_type KIND_CMP = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_Q,
      ST_MUL_D,
      ST_CMP,
      ST_ADD,
      ST_ADD_SWAP,
      ST_GCD_INIT,
      ST_GCD,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/rational_arith_normalize.sv
// ----------------------------------------------------------------------------
// rational_arith_normalize
// Sequence: unused kinds and zero denominators go straight to the result;
// compare forms and compares both cross-products; add/sub/mul/div form
// products, add for add/sub, reduce a nonzero result by binary GCD and,
// unless the GCD is one, run two 64-step restoring divisions on one 65-bit adder.
// Throughput: one word at a time; req_ready is high only while idle, the cycle
// after the result is registered; a result left unread holds the sequencer.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
module rational_arith_normalize
   import rat_norm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [FIELD_W-1:0] req_a_num,
   input  logic signed [FIELD_W-1:0] req_a_den,
   input  logic signed [FIELD_W-1:0] req_b_num,
   input  logic signed [FIELD_W-1:0] req_b_den,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [FIELD_W-1:0] rsp_res_num,
   output logic [FIELD_W-2:0]        rsp_res_den,
   output logic                      rsp_is_equal,
   output logic                      rsp_div_zero,
   output logic                      rsp_overflow
);

   state_type state_ff, state_in;

   kind_type           kind_ff, kind_in;
   logic [FIELD_W-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic               an_neg_ff, an_neg_in, ad_neg_ff, ad_neg_in;
   logic               bn_neg_ff, bn_neg_in, bd_neg_ff, bd_neg_in;
   logic [MAG_W-1:0]   n_ff, n_in, d_ff, d_in, q_ff, q_in;
   logic               n_neg_ff, n_neg_in, d_neg_ff, d_neg_in, q_neg_ff, q_neg_in;
   logic [MAG_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [CNT_W-1:0]   k_ff, k_in, cnt_ff, cnt_in;
   logic [MAG_W-1:0]   rem_ff, rem_in, quo_ff, quo_in;
   logic               div_sel_ff, div_sel_in;
   logic               calc_ff, calc_in, eq_ff, eq_in, dz_ff, dz_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [FIELD_W-1:0] out_num_ff, out_num_in;
   logic [FIELD_W-2:0]        out_den_ff, out_den_in;
   logic                      out_eq_ff, out_eq_in, out_dz_ff, out_dz_in;
   logic                      out_ovf_ff, out_ovf_in;
   logic                      out_load;

   // shared multiplier and add/sub unit
   logic [FIELD_W-1:0] mul_a, mul_b;
   logic [MAG_W-1:0]   mul_res;
   logic [MAG_W:0]     alu_a, alu_b;
   logic               alu_sub;
   logic [MAG_W+1:0]   alu_res;
   logic               borrow;

   logic [MAG_W:0]     rem_sh;
   logic               res_neg, fits;

   assign mul_res = MAG_W'(mul_a) * MAG_W'(mul_b);
   assign alu_res = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                    + {{(MAG_W+1){1'b0}}, alu_sub};
   assign borrow  = alu_res[MAG_W+1];
   assign rem_sh  = {rem_ff, quo_ff[MAG_W-1]};

   assign res_neg = n_neg_ff ^ d_neg_ff;
   assign fits    = (res_neg ? (n_ff <= LIM) : (n_ff < LIM)) && (d_ff < LIM);

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = out_num_ff;
   assign rsp_res_den  = out_den_ff;
   assign rsp_is_equal = out_eq_ff;
   assign rsp_div_zero = out_dz_ff;
   assign rsp_overflow = out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      an_neg_ff  <= an_neg_in;
      ad_neg_ff  <= ad_neg_in;
      bn_neg_ff  <= bn_neg_in;
      bd_neg_ff  <= bd_neg_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      q_ff       <= q_in;
      n_neg_ff   <= n_neg_in;
      d_neg_ff   <= d_neg_in;
      q_neg_ff   <= q_neg_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_sel_ff <= div_sel_in;
      calc_ff    <= calc_in;
      eq_ff      <= eq_in;
      dz_ff      <= dz_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_eq_ff  <= out_eq_in;
      out_dz_ff  <= out_dz_in;
      out_ovf_ff <= out_ovf_in;
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      an_neg_in  = an_neg_ff;
      ad_neg_in  = ad_neg_ff;
      bn_neg_in  = bn_neg_ff;
      bd_neg_in  = bd_neg_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      q_in       = q_ff;
      n_neg_in   = n_neg_ff;
      d_neg_in   = d_neg_ff;
      q_neg_in   = q_neg_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_sel_in = div_sel_ff;
      calc_in    = calc_ff;
      eq_in      = eq_ff;
      dz_in      = dz_ff;
      mul_a      = an_ff;
      mul_b      = bd_ff;
      alu_a      = {1'b0, x_ff};
      alu_b      = {1'b0, y_ff};
      alu_sub    = 1'b1;
      out_load   = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               an_neg_in = req_a_num[FIELD_W-1];
               ad_neg_in = req_a_den[FIELD_W-1];
               bn_neg_in = req_b_num[FIELD_W-1];
               bd_neg_in = req_b_den[FIELD_W-1];
               an_in     = req_a_num[FIELD_W-1] ? FIELD_W'(0) - req_a_num : req_a_num;
               ad_in     = req_a_den[FIELD_W-1] ? FIELD_W'(0) - req_a_den : req_a_den;
               bn_in     = req_b_num[FIELD_W-1] ? FIELD_W'(0) - req_b_num : req_b_num;
               bd_in     = req_b_den[FIELD_W-1] ? FIELD_W'(0) - req_b_den : req_b_den;
               calc_in   = 1'b0;
               eq_in     = 1'b0;
               dz_in     = 1'b0;
               if (req_kind > KIND_CMP) begin
                  state_in = ST_DONE;
               end else if (req_a_den == '0 || req_b_den == '0 ||
                            (req_kind == KIND_DIV && req_b_num == '0)) begin
                  dz_in    = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL_P;
               end
            end
         end

         ST_MUL_P: begin
            mul_a    = an_ff;
            mul_b    = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
            n_in     = mul_res;
            n_neg_in = an_neg_ff ^ ((kind_ff == KIND_MUL) ? bn_neg_ff : bd_neg_ff);
            if (kind_ff == KIND_MUL || kind_ff == KIND_DIV) begin
               state_in = ST_MUL_D;
            end else begin
               state_in = ST_MUL_Q;
            end
         end

         ST_MUL_Q: begin
            mul_a    = bn_ff;
            mul_b    = ad_ff;
            q_in     = mul_res;
            q_neg_in = bn_neg_ff ^ ad_neg_ff ^ (kind_ff == KIND_SUB);
            state_in = (kind_ff == KIND_CMP) ? ST_CMP : ST_MUL_D;
         end

         ST_MUL_D: begin
            mul_a    = ad_ff;
            mul_b    = (kind_ff == KIND_DIV) ? bn_ff : bd_ff;
            d_in     = mul_res;
            d_neg_in = ad_neg_ff ^ ((kind_ff == KIND_DIV) ? bn_neg_ff : bd_neg_ff);
            if (kind_ff == KIND_ADD || kind_ff == KIND_SUB) begin
               state_in = ST_ADD;
            end else begin
               state_in = ST_GCD_INIT;
            end
         end

         ST_CMP: begin
            // a zero product carries no sign
            eq_in    = (n_ff == q_ff) && (n_ff == '0 || n_neg_ff == q_neg_ff);
            state_in = ST_DONE;
         end

         ST_ADD: begin
            alu_a   = {1'b0, n_ff};
            alu_b   = {1'b0, q_ff};
            alu_sub = (n_neg_ff != q_neg_ff);
            if (alu_sub && borrow) begin
               state_in = ST_ADD_SWAP;
            end else begin
               n_in     = alu_res[MAG_W-1:0];
               state_in = ST_GCD_INIT;
            end
         end

         ST_ADD_SWAP: begin
            alu_a    = {1'b0, q_ff};
            alu_b    = {1'b0, n_ff};
            n_in     = alu_res[MAG_W-1:0];
            n_neg_in = q_neg_ff;
            state_in = ST_GCD_INIT;
         end

         ST_GCD_INIT: begin
            x_in = n_ff;
            y_in = d_ff;
            k_in = '0;
            if (n_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               calc_in  = 1'b1;
               state_in = ST_GCD;
            end
         end

         ST_GCD: begin
            // y never reaches zero; y holds the odd part of the GCD at the end
            if (x_ff == '0) begin
               div_sel_in = 1'b0;
               if (y_ff == MAG_W'(1) && k_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV_INIT;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CNT_W'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (borrow) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               // odd minus odd is even: fold the halving into the subtract
               x_in = alu_res[MAG_W:1];
            end
         end

         ST_DIV_INIT: begin
            quo_in   = (div_sel_ff ? d_ff : n_ff) >> k_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            alu_a  = rem_sh;
            alu_b  = {1'b0, y_ff};
            rem_in = borrow ? rem_sh[MAG_W-1:0] : alu_res[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], !borrow};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               if (div_sel_ff) begin
                  d_in     = quo_in;
                  state_in = ST_DONE;
               end else begin
                  n_in       = quo_in;
                  div_sel_in = 1'b1;
                  state_in   = ST_DIV_INIT;
               end
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      out_eq_in  = out_eq_ff;
      out_dz_in  = out_dz_ff;
      out_ovf_in = out_ovf_ff;
      if (out_load) begin
         out_eq_in  = eq_ff;
         out_dz_in  = dz_ff;
         out_ovf_in = calc_ff && !fits;
         if (calc_ff && fits) begin
            out_num_in = res_neg ? FIELD_W'(0) - n_ff[FIELD_W-1:0] : n_ff[FIELD_W-1:0];
            out_den_in = d_ff[FIELD_W-2:0];
         end else begin
            out_num_in = '0;
            out_den_in = (FIELD_W-1)'(1);
         end
      end
   end

   // not ready again in the cycle after taking a word
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after accept");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_res_den != '0))
      else $error("zero denominator in result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_div_zero || rsp_overflow)) |->
         (rsp_res_num == '0 && rsp_res_den == (FIELD_W-1)'(1) && !rsp_is_equal))
      else $error("flagged result is not 0/1");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_equal) |-> (rsp_res_num == '0 && !rsp_div_zero && !rsp_overflow))
      else $error("compare result carries a fraction or flag");

endmodule

FILE: dv/rational_arith_normalize_test.sv
// ----------------------------------------------------------------------------
// rational_arith_normalize_test
// Self-checking bench for the rational add/sub/mul/div/compare unit. Request
// words are offered in random bursts while the response side stalls on its
// own pattern. Every accepted request is run through a local sign-magnitude
// predictor (double-width cross-products, sign fold, gcd reduction, range
// check), and each response word is compared field by field, in order.
// ----------------------------------------------------------------------------
module rational_arith_normalize_test
   import rat_norm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } signed_mag_t;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        eq;
      logic        dz;
      logic        ovf;
   } ratio_result_t;

   localparam kind_type    KIND_LAST = '1;
   localparam logic [31:0] TERM_MIN  = 32'h8000_0000;
   localparam logic [31:0] TERM_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] TERM_NEG1 = 32'hFFFF_FFFF;
   localparam logic [63:0] FIT_LIMIT = 64'd1 << (WIDTH - 1);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [KIND_W-1:0]         req_kind = KIND_ADD;
   logic [FIELD_W-1:0]        req_a_num = '0;
   logic [FIELD_W-1:0]        req_a_den = '0;
   logic [FIELD_W-1:0]        req_b_num = '0;
   logic [FIELD_W-1:0]        req_b_den = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [FIELD_W-1:0] rsp_res_num;
   logic [FIELD_W-2:0]        rsp_res_den;
   logic                      rsp_is_equal;
   logic                      rsp_div_zero;
   logic                      rsp_overflow;

   ratio_result_t pending_ratios[$];
   int            mismatch_count = 0;
   int            burst_left     = 0;
   bit            sender_gaps_on = 1'b1;
   bit            rsp_stall_on   = 1'b1;
   int            rsp_hold_req   = 0;
   int            hold_left      = 0;
   int            pattern_left   = 0;
   int            stall_mode     = 0;
   int            stall_phase    = 0;

   rational_arith_normalize dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_is_equal (rsp_is_equal),
      .rsp_div_zero (rsp_div_zero),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic signed_mag_t to_signed_mag(logic [31:0] v);
      signed_mag_t s;
      s.neg = v[31];
      s.mag = {32'd0, v[31] ? (32'd0 - v) : v};
      return s;
   endfunction

   function automatic signed_mag_t mag_product(signed_mag_t x, signed_mag_t y);
      signed_mag_t r;
      r.mag = x.mag * y.mag;
      r.neg = (r.mag != 0) && (x.neg != y.neg);
      return r;
   endfunction

   function automatic signed_mag_t mag_sum(signed_mag_t x, signed_mag_t y);
      signed_mag_t r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic ratio_result_t predict_reduced(kind_type kind, logic [31:0] an,
                                                     logic [31:0] ad, logic [31:0] bn,
                                                     logic [31:0] bd);
      signed_mag_t   xa, ya, xb, yb, num, den, p, q;
      logic [63:0]   u, v, t, nm, dm;
      logic          neg, fits;
      ratio_result_t r;
      xa = to_signed_mag(an);
      ya = to_signed_mag(ad);
      xb = to_signed_mag(bn);
      yb = to_signed_mag(bd);
      r  = '{num: 32'd0, den: 31'd1, eq: 1'b0, dz: 1'b0, ovf: 1'b0};
      if (kind <= KIND_CMP && (ya.mag == 0 || yb.mag == 0)) begin
         r.dz = 1'b1;
      end else if (kind == KIND_CMP) begin
         p    = mag_product(xa, yb);
         q    = mag_product(xb, ya);
         r.eq = (p == q);
      end else if (kind <= KIND_DIV) begin
         case (kind)
            KIND_ADD, KIND_SUB: begin
               q = mag_product(xb, ya);
               if (kind == KIND_SUB && q.mag != 0) q.neg = !q.neg;
               num = mag_sum(mag_product(xa, yb), q);
               den = mag_product(ya, yb);
            end
            KIND_MUL: begin
               num = mag_product(xa, xb);
               den = mag_product(ya, yb);
            end
            default: begin
               num = mag_product(xa, yb);
               den = mag_product(ya, xb);
            end
         endcase
         if (den.mag == 0) begin
            r.dz = 1'b1;
         end else if (num.mag != 0) begin
            neg = num.neg != den.neg;
            u   = num.mag;
            v   = den.mag;
            while (v != 0) begin
               t = u % v;
               u = v;
               v = t;
            end
            nm   = num.mag / u;
            dm   = den.mag / u;
            fits = (neg ? (nm <= FIT_LIMIT) : (nm < FIT_LIMIT)) && (dm < FIT_LIMIT);
            if (fits) begin
               r.num = neg ? 32'(64'd0 - nm) : nm[31:0];
               r.den = dm[30:0];
            end else begin
               r.ovf = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic offer_ratio_word(input kind_type kind, input logic [31:0] an,
                                   input logic [31:0] ad, input logic [31:0] bn,
                                   input logic [31:0] bd);
      int gap;
      if (sender_gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_ratios.push_back(predict_reduced(kind, an, ad, bn, bd));
   endtask

   // terms in -32..32 but for wide_pct percent wide ones, so reduction and zero denominators show up often
   function automatic logic [31:0] rand_term(int wide_pct);
      logic [31:0] v;
      if ($urandom_range(0, 99) < wide_pct) begin
         case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
               case ($urandom_range(0, 5))
                  0: v = TERM_MIN;
                  1: v = TERM_MAX;
                  2: v = TERM_NEG1;
                  3: v = TERM_MIN + 1;
                  4: v = 32'd1;
                  default: v = 32'd0;
               endcase
            end
            2: v = $urandom_range(1, 255) << $urandom_range(0, 23);
            default: v = $urandom_range(1, 65535) * $urandom_range(1, 40000);
         endcase
      end else begin
         v = $urandom_range(0, 64) - 32;
      end
      if ($urandom_range(0, 3) == 0) v = 32'd0 - v;
      return v;
   endfunction

   function automatic kind_type pick_kind(int unused_pct);
      if ($urandom_range(0, 99) < unused_pct)
         return kind_type'($urandom_range(KIND_LAST, KIND_CMP + 1));
      return kind_type'($urandom_range(KIND_CMP, KIND_ADD));
   endfunction

   // ------------------------------------------------------------------------
   // response side: own stall pattern, plus a counted hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         hold_left    = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!rsp_stall_on) begin
         rsp_ready <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 200);
         end
         pattern_left--;
         stall_phase++;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= (stall_phase % 3) != 0;
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      ratio_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ratios.size() == 0) begin
            $error("response word with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_ratios.pop_front();
            check_field("res_num", {{32{want.num[31]}}, want.num},
                        {{32{rsp_res_num[31]}}, rsp_res_num});
            check_field("res_den", 64'(want.den), 64'(rsp_res_den));
            check_field("is_equal", 64'(want.eq), 64'(rsp_is_equal));
            check_field("div_zero", 64'(want.dz), 64'(rsp_div_zero));
            check_field("overflow", 64'(want.ovf), 64'(rsp_overflow));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_corners();
      offer_ratio_word(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      offer_ratio_word(KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      offer_ratio_word(KIND_MUL, -32'd2, 32'd3, 32'd3, -32'd4);
      offer_ratio_word(KIND_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
      offer_ratio_word(KIND_ADD, 32'd7, 32'd0, 32'd1, 32'd1);
      offer_ratio_word(KIND_CMP, 32'd1, 32'd2, 32'd1, 32'd0);
      offer_ratio_word(KIND_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
      offer_ratio_word(KIND_CMP, 32'd1, 32'd2, -32'd2, -32'd4);
      offer_ratio_word(KIND_CMP, 32'd1, 32'd2, 32'd1, 32'd3);
      offer_ratio_word(KIND_SUB, 32'd5, -32'd10, 32'd0, 32'd7);
      offer_ratio_word(KIND_ADD, TERM_MAX, 32'd1, 32'd1, 32'd1);
      offer_ratio_word(KIND_SUB, TERM_MIN, 32'd1, 32'd1, 32'd1);
      offer_ratio_word(KIND_MUL, TERM_MIN, 32'd1, TERM_NEG1, 32'd1);
      offer_ratio_word(KIND_MUL, TERM_MIN, 32'd1, 32'd1, 32'd1);
      offer_ratio_word(KIND_DIV, 32'd1, 32'd1, 32'd1, TERM_MIN);
      offer_ratio_word(KIND_DIV, 32'd1, TERM_MIN, 32'd1, 32'd1);
      offer_ratio_word(KIND_MUL, TERM_MAX, TERM_MAX, TERM_MIN, TERM_MIN);
      offer_ratio_word(KIND_MUL, TERM_MIN, TERM_MIN, TERM_MIN, TERM_MIN);
      offer_ratio_word(KIND_ADD, 32'd1, TERM_MAX, 32'd1, TERM_MAX - 1);
      offer_ratio_word(KIND_CMP, TERM_MIN, 32'd1, TERM_MIN, 32'd1);
      offer_ratio_word(KIND_CMP, TERM_NEG1, TERM_NEG1, 32'd1, 32'd1);
      offer_ratio_word(KIND_DIV, 32'd0, 32'd3, 32'd4, 32'd5);
      offer_ratio_word(KIND_ADD, TERM_NEG1, TERM_NEG1, TERM_NEG1, TERM_NEG1);
      offer_ratio_word(kind_type'(KIND_CMP + 1), 32'd3, 32'd0, 32'd5, 32'd0);
      offer_ratio_word(KIND_LAST, TERM_MIN, TERM_MAX, TERM_NEG1, TERM_MIN);
   endtask

   task automatic test_random_small_terms(input int count);
      repeat (count)
         offer_ratio_word(pick_kind(5), rand_term(10), rand_term(10), rand_term(10),
                          rand_term(10));
   endtask

   task automatic test_random_wide_terms(input int count);
      repeat (count)
         offer_ratio_word(pick_kind(10), rand_term(70), rand_term(70), rand_term(70),
                          rand_term(70));
   endtask

   // scale one fraction into the other so equality and full reduction are hit
   task automatic test_compare_scaled(input int count);
      logic [31:0] an, ad, k, bn, bd;
      kind_type    kind;
      repeat (count) begin
         an = $urandom_range(0, 2000) - 1000;
         ad = $urandom_range(0, 2000) - 1000;
         k  = $urandom_range(1, 3000);
         if ($urandom_range(0, 1)) k = 32'd0 - k;
         bn = an * k;
         bd = ad * k;
         if ($urandom_range(0, 3) == 0) bn = bn + 1;
         kind = ($urandom_range(0, 2) != 0) ? KIND_CMP : pick_kind(0);
         offer_ratio_word(kind, an, ad, bn, bd);
      end
   endtask

   task automatic test_back_to_back(input int count);
      sender_gaps_on = 1'b0;
      rsp_stall_on   = 1'b0;
      test_random_small_terms(count);
      sender_gaps_on = 1'b1;
      rsp_stall_on   = 1'b1;
   endtask

   // hold the response side while requests keep coming, so the input stalls
   task automatic test_receiver_holdoff(input int count);
      sender_gaps_on = 1'b0;
      rsp_hold_req   = 700;
      test_random_wide_terms(count);
      sender_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_random_small_terms(450);
      test_receiver_holdoff(12);
      test_random_wide_terms(340);
      test_compare_scaled(120);
      test_back_to_back(150);
      test_receiver_holdoff(12);
      req_valid <= 1'b0;
      while (pending_ratios.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: rational_arith_normalize.f
hdl/rat_norm_pkg.sv
hdl/rational_arith_normalize.sv
dv/rational_arith_normalize_test.sv
